/* sv/anb2lp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the Annex B to length-prefixed converter.
// No dependencies; used by the front end, the back end and the top level.
package anb2lp_pkg;

  // Width of the length and offset counters
  localparam int COUNT_BITS_DEFAULT = 24;
  // Depth of the command queue between front and back (power of two)
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Result field widths
  localparam int BYTE_W   = 8;
  localparam int FIELD_W  = 24;
  localparam int KIND_W   = 2;
  localparam int PSIZE_W  = 3;
  localparam int NZERO_W  = 3;

  localparam logic [PSIZE_W-1:0] PREFIX_SIZE_RESET = 3'd4;
  localparam logic [BYTE_W-1:0]  START_CODE_BYTE   = 8'h01;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LENGTH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

  // Record emitted at the end of a command
  localparam logic [1:0] POST_NONE  = 2'd0;
  localparam logic [1:0] POST_CLOSE = 2'd1;
  localparam logic [1:0] POST_ERROR = 2'd2;

  // Control part of one queued command; counts and offsets travel beside it
  typedef struct packed {
    logic               pre_valid;   // close previous unit first
    logic [NZERO_W-1:0] nzero;       // zero payload bytes to emit
    logic               byte_valid;  // then one data payload byte
    logic [BYTE_W-1:0]  data_byte;
    logic [1:0]         post;        // final record of the access unit
  } cmd_ctl_t;

endpackage

/* sv/annexb_to_length_prefixed.sv */
`timescale 1ns / 1ps
// Annex B to length-prefixed converter, top level.
// Depends on anb2lp_pkg, anb2lp_front, anb2lp_queue and anb2lp_back.
//
// Input stream: one byte of an Annex B access unit per transaction, s_tlast
// on the final byte. Output stream: one result per transaction. m_tuser is
// the kind (payload byte, length record, error); m_tdata carries the payload
// byte, the unit length and the output offset; m_tlast marks the final
// result of the access unit. Start codes are stripped; each unit ends with a
// length record giving where a big-endian prefix of prefix_size bytes goes.
// The front end takes one byte per cycle while the command queue has room.
// Each byte gives a command of zero to five results; while the receiver is
// ready, the back end emits one result per cycle, so the sustained rate is
// one byte per cycle as long as bytes average at most one result; runs of
// held zeros and length records are absorbed by the queue. When the receiver
// stalls, the output register holds, then the queue fills and s_tready drops.
// Reset clears all unit state, empties the queue and sets prefix_size to 4.
// The user must write cfg_data only while the block idles; it is not enforced.
module annexb_to_length_prefixed import anb2lp_pkg::*; #(
  parameter int COUNT_BITS  = COUNT_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [PSIZE_W-1:0] cfg_data,     // prefix_size
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,      // data_byte
  input  logic               s_tlast,      // last_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [55:0]        m_tdata,      // out_byte, unit_length, out_offset
  output logic [KIND_W-1:0]  m_tuser,      // kind
  output logic               m_tlast       // last_result
);

  localparam int CMD_W = $bits(cmd_ctl_t) + 5 * COUNT_BITS;

  logic [PSIZE_W-1:0]    prefix_size;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  cmd_ctl_t              f_ctl;
  cmd_ctl_t              b_ctl;
  logic [COUNT_BITS-1:0] f_pre_len, f_pre_off, f_base_off, f_post_len, f_post_off;
  logic [COUNT_BITS-1:0] b_pre_len, b_pre_off, b_base_off, b_post_len, b_post_off;
  logic [CMD_W-1:0]      q_in;
  logic [CMD_W-1:0]      q_out;
  logic [BYTE_W-1:0]     res_byte;
  logic [FIELD_W-1:0]    res_length;
  logic [FIELD_W-1:0]    res_offset;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_size <= PREFIX_SIZE_RESET;
    end else if (cfg_valid) begin
      prefix_size <= cfg_data;
    end
  end

  anb2lp_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .prefix_size (prefix_size),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_byte     (s_tdata),
    .in_last     (s_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .cmd_ctl     (f_ctl),
    .pre_len     (f_pre_len),
    .pre_off     (f_pre_off),
    .base_off    (f_base_off),
    .post_len    (f_post_len),
    .post_off    (f_post_off)
  );

  assign q_in = {f_post_off, f_post_len, f_base_off, f_pre_off, f_pre_len, f_ctl};
  assign {b_post_off, b_post_len, b_base_off, b_pre_off, b_pre_len, b_ctl} = q_out;

  anb2lp_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  anb2lp_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .cmd_ctl    (b_ctl),
    .pre_len    (b_pre_len),
    .pre_off    (b_pre_off),
    .base_off   (b_base_off),
    .post_len   (b_post_len),
    .post_off   (b_post_off),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_byte   (res_byte),
    .out_length (res_length),
    .out_offset (res_offset),
    .out_last   (m_tlast)
  );

  assign m_tdata = {res_offset, res_length, res_byte};

  // Error records always close the access unit
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_ERROR) |-> m_tlast)
    else $error("error record without last flag");

  // Payload results never carry a length and never close the unit
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_PAYLOAD) |-> (!m_tlast && m_tdata[31:8] == '0))
    else $error("payload result with length or last flag");

  // The queue is never written while full nor read while empty
  assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full) && !(q_pop && q_empty))
    else $error("command queue overrun or underrun");

endmodule

/* sv/anb2lp_front.sv */
`timescale 1ns / 1ps
// Front end: takes one byte per transaction, tracks start codes and unit
// state, and turns each byte into a compact command. Depends on anb2lp_pkg.
module anb2lp_front import anb2lp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [PSIZE_W-1:0]    prefix_size,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic                  in_last,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_ctl_t              cmd_ctl,
  output logic [COUNT_BITS-1:0] pre_len,
  output logic [COUNT_BITS-1:0] pre_off,
  output logic [COUNT_BITS-1:0] base_off,
  output logic [COUNT_BITS-1:0] post_len,
  output logic [COUNT_BITS-1:0] post_off
);

  logic [1:0]            zero_run;
  logic                  at_first_byte;
  logic                  first_byte_bad;
  logic                  inside_unit;
  logic [COUNT_BITS-1:0] unit_count;
  logic [COUNT_BITS-1:0] unit_prefix_offset;
  logic [COUNT_BITS-1:0] output_position;

  logic                  accept;
  logic                  bad_now;
  logic                  start_code;
  logic                  pre_close;
  logic                  unit_error;
  logic [1:0]            zero_run_next;
  logic                  inside_next;
  logic [NZERO_W-1:0]    zeros;
  logic                  emit_byte;
  logic [NZERO_W-1:0]    pay_count;
  logic [COUNT_BITS:0]   count_sum;
  logic [COUNT_BITS-1:0] count_base;
  logic [COUNT_BITS-1:0] unit_count_next;
  logic [COUNT_BITS-1:0] prefix_offset_next;
  logic [COUNT_BITS-1:0] position_next;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the byte against the held zero run
  always_comb begin
    bad_now       = at_first_byte ? (in_byte != '0) : first_byte_bad;
    start_code    = 1'b0;
    pre_close     = 1'b0;
    zero_run_next = zero_run;
    inside_next   = inside_unit;
    zeros         = '0;
    emit_byte     = 1'b0;
    if (!bad_now) begin
      if (in_byte == '0) begin
        if (zero_run == 2'd3) begin
          zeros = NZERO_W'(1);
        end else begin
          zero_run_next = zero_run + 2'd1;
        end
      end else if (in_byte == START_CODE_BYTE && zero_run >= 2'd2) begin
        start_code    = 1'b1;
        pre_close     = inside_unit;
        inside_next   = 1'b1;
        zero_run_next = '0;
      end else begin
        zeros         = NZERO_W'(zero_run);
        zero_run_next = '0;
        emit_byte     = 1'b1;
      end
    end
    // payload only counts once a start code was seen
    if (!inside_unit) begin
      zeros     = '0;
      emit_byte = 1'b0;
    end
    unit_error = in_last && (bad_now || !inside_next);
    // trailing held zeros belong to the payload
    if (in_last && !unit_error) begin
      zeros = zeros + NZERO_W'(zero_run_next);
    end
    if (unit_error) begin
      zeros     = '0;
      emit_byte = 1'b0;
      pre_close = 1'b0;
    end
  end

  // Length, prefix offset and output position after this byte
  always_comb begin
    pay_count          = zeros + NZERO_W'(emit_byte);
    count_base         = start_code ? '0 : unit_count;
    count_sum          = {1'b0, count_base} + (COUNT_BITS + 1)'(pay_count);
    unit_count_next    = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
    prefix_offset_next = start_code ? output_position : unit_prefix_offset;
    position_next      = output_position + (start_code ? COUNT_BITS'(prefix_size)
                                                       : COUNT_BITS'(pay_count));
  end

  // Command toward the back end
  always_comb begin
    cmd_ctl.pre_valid  = pre_close;
    cmd_ctl.nzero      = zeros;
    cmd_ctl.byte_valid = emit_byte;
    cmd_ctl.data_byte  = in_byte;
    cmd_ctl.post       = unit_error ? POST_ERROR : (in_last ? POST_CLOSE : POST_NONE);
    pre_len            = unit_count;
    pre_off            = unit_prefix_offset;
    base_off           = output_position;
    post_len           = unit_count_next;
    post_off           = prefix_offset_next;
    q_push             = accept && (pre_close || zeros != '0 || emit_byte || in_last);
  end

  // Unit state
  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      zero_run           <= '0;
      at_first_byte      <= 1'b1;
      first_byte_bad     <= 1'b0;
      inside_unit        <= 1'b0;
      unit_count         <= '0;
      unit_prefix_offset <= '0;
      output_position    <= '0;
    end else if (accept) begin
      zero_run           <= zero_run_next;
      at_first_byte      <= 1'b0;
      first_byte_bad     <= bad_now;
      inside_unit        <= inside_next;
      unit_count         <= unit_count_next;
      unit_prefix_offset <= prefix_offset_next;
      output_position    <= position_next;
    end
  end

endmodule

/* sv/anb2lp_queue.sv */
`timescale 1ns / 1ps
// Command queue between front and back end: small register FIFO with
// simultaneous push and pop. Depends on anb2lp_pkg for defaults.
module anb2lp_queue import anb2lp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/anb2lp_back.sv */
`timescale 1ns / 1ps
// Back end: expands each queued command into result transactions, one per
// unstalled cycle, into a registered output stage. Depends on anb2lp_pkg.
module anb2lp_back import anb2lp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  cmd_ctl_t              cmd_ctl,
  input  logic [COUNT_BITS-1:0] pre_len,
  input  logic [COUNT_BITS-1:0] pre_off,
  input  logic [COUNT_BITS-1:0] base_off,
  input  logic [COUNT_BITS-1:0] post_len,
  input  logic [COUNT_BITS-1:0] post_off,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_kind,
  output logic [BYTE_W-1:0]     out_byte,
  output logic [FIELD_W-1:0]    out_length,
  output logic [FIELD_W-1:0]    out_offset,
  output logic                  out_last
);

  // Command being expanded
  logic                  active;
  logic                  pre_pend;
  logic [NZERO_W-1:0]    zeros_left;
  logic                  byte_pend;
  logic [1:0]            post_pend;
  logic [BYTE_W-1:0]     cur_byte;
  logic [COUNT_BITS-1:0] cur_pre_len;
  logic [COUNT_BITS-1:0] cur_pre_off;
  logic [COUNT_BITS-1:0] cur_post_len;
  logic [COUNT_BITS-1:0] cur_post_off;
  logic [COUNT_BITS-1:0] cur_off;

  logic                  load;
  logic                  emit;
  logic                  pre_pend_next;
  logic [NZERO_W-1:0]    zeros_left_next;
  logic                  byte_pend_next;
  logic [1:0]            post_pend_next;
  logic                  advance;
  logic                  done;
  logic [KIND_W-1:0]     kind_next;
  logic [BYTE_W-1:0]     byte_next;
  logic [FIELD_W-1:0]    length_next;
  logic [FIELD_W-1:0]    offset_next;
  logic                  last_next;

  assign load  = !out_valid || out_ready;
  assign emit  = active && load;
  assign q_pop = !q_empty && (!active || (emit && done));

  // Pick the next result in order: close, zeros, byte, final record
  always_comb begin
    pre_pend_next   = pre_pend;
    zeros_left_next = zeros_left;
    byte_pend_next  = byte_pend;
    post_pend_next  = post_pend;
    advance         = 1'b0;
    kind_next       = KIND_PAYLOAD;
    byte_next       = '0;
    length_next     = '0;
    offset_next     = FIELD_W'(cur_off);
    last_next       = 1'b0;
    if (pre_pend) begin
      pre_pend_next = 1'b0;
      kind_next     = KIND_LENGTH;
      length_next   = FIELD_W'(cur_pre_len);
      offset_next   = FIELD_W'(cur_pre_off);
    end else if (zeros_left != '0) begin
      zeros_left_next = zeros_left - NZERO_W'(1);
      advance         = 1'b1;
    end else if (byte_pend) begin
      byte_pend_next = 1'b0;
      byte_next      = cur_byte;
      advance        = 1'b1;
    end else begin
      post_pend_next = POST_NONE;
      last_next      = 1'b1;
      if (post_pend == POST_ERROR) begin
        kind_next   = KIND_ERROR;
        offset_next = '0;
      end else begin
        kind_next   = KIND_LENGTH;
        length_next = FIELD_W'(cur_post_len);
        offset_next = FIELD_W'(cur_post_off);
      end
    end
    done = !pre_pend_next && zeros_left_next == '0 && !byte_pend_next &&
           post_pend_next == POST_NONE;
  end

  // Command registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (q_pop) begin
      active <= 1'b1;
    end else if (emit && done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pre_pend     <= cmd_ctl.pre_valid;
      zeros_left   <= cmd_ctl.nzero;
      byte_pend    <= cmd_ctl.byte_valid;
      post_pend    <= cmd_ctl.post;
      cur_byte     <= cmd_ctl.data_byte;
      cur_pre_len  <= pre_len;
      cur_pre_off  <= pre_off;
      cur_post_len <= post_len;
      cur_post_off <= post_off;
      cur_off      <= base_off;
    end else if (emit) begin
      pre_pend   <= pre_pend_next;
      zeros_left <= zeros_left_next;
      byte_pend  <= byte_pend_next;
      post_pend  <= post_pend_next;
      if (advance) begin
        cur_off <= cur_off + COUNT_BITS'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= kind_next;
      out_byte   <= byte_next;
      out_length <= length_next;
      out_offset <= offset_next;
      out_last   <= last_next;
    end
  end

endmodule

/* tb/annexb_stream_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for annexb_to_length_prefixed: predicts the result stream from
// the accepted bytes and compares it with what the block emits.
// Depends on anb2lp_pkg for field widths and result kinds.
module annexb_stream_checker import anb2lp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [PSIZE_W-1:0] cfg_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               s_tlast,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [55:0]        m_tdata,
  input  logic [KIND_W-1:0]  m_tuser,
  input  logic               m_tlast,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] offs;
    logic               fin;
  } au_result_t;

  au_result_t expected_results[$];

  // Predicted converter state
  logic [PSIZE_W-1:0] prefix_bytes;
  logic [1:0]         held_zeros;
  logic               opening;
  logic               lead_bad;
  logic               nal_open;
  logic [FIELD_W-1:0] nal_len;
  logic [FIELD_W-1:0] prefix_at;
  logic [FIELD_W-1:0] out_pos;
  int                 errs;
  int                 n_checked;

  function automatic void clear_unit();
    held_zeros = '0;
    opening    = 1'b1;
    lead_bad   = 1'b0;
    nal_open   = 1'b0;
    nal_len    = '0;
    prefix_at  = '0;
    out_pos    = '0;
  endfunction

  // Payload bytes only count once a start code has opened a NAL unit
  function automatic void emit_payload(input logic [7:0] b);
    if (nal_open) begin
      expected_results.push_back(au_result_t'{KIND_PAYLOAD, b, '0, out_pos, 1'b0});
      out_pos = out_pos + 1'b1;
      if (nal_len != '1) nal_len = nal_len + 1'b1;
    end
  endfunction

  function automatic void close_nal(input logic fin);
    expected_results.push_back(au_result_t'{KIND_LENGTH, 8'h00, nal_len, prefix_at, fin});
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic fin);
    if (opening) begin
      opening = 1'b0;
      if (b != 8'h00) lead_bad = 1'b1;
    end
    if (!lead_bad) begin
      if (b == 8'h00) begin
        // fourth zero pushes the oldest held one out as payload
        if (held_zeros == 2'd3) emit_payload(8'h00);
        else held_zeros = held_zeros + 1'b1;
      end else if (b == START_CODE_BYTE && held_zeros >= 2'd2) begin
        if (nal_open) close_nal(1'b0);
        nal_open   = 1'b1;
        held_zeros = '0;
        nal_len    = '0;
        prefix_at  = out_pos;
        out_pos    = out_pos + FIELD_W'(prefix_bytes);
      end else begin
        repeat (held_zeros) emit_payload(8'h00);
        held_zeros = '0;
        emit_payload(b);
      end
    end
    if (fin) begin
      if (lead_bad || !nal_open) begin
        expected_results.push_back(au_result_t'{KIND_ERROR, 8'h00, '0, '0, 1'b1});
      end else begin
        // trailing zeros belong to the last payload
        repeat (held_zeros) emit_payload(8'h00);
        close_nal(1'b1);
      end
      clear_unit();
    end
  endfunction

  always @(posedge clk) begin : watch
    au_result_t got;
    au_result_t want;
    if (rst) begin
      expected_results.delete();
      prefix_bytes = PREFIX_SIZE_RESET;
      clear_unit();
      errs      = 0;
      n_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) prefix_bytes = cfg_data;
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got = au_result_t'{m_tuser, m_tdata[7:0], m_tdata[31:8], m_tdata[55:32], m_tlast};
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual kind %0d byte %h len %0d off %0d last %b",
                     $time, got.kind, got.data, got.len, got.offs, got.fin);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (got !== want) begin
            errs++;
            if (errs <= MAX_REPORTS) begin
              if (got.kind !== want.kind)
                $display("%0t: kind mismatch, expected %0d actual %0d",
                         $time, want.kind, got.kind);
              if (got.data !== want.data)
                $display("%0t: out_byte mismatch, expected %h actual %h",
                         $time, want.data, got.data);
              if (got.len !== want.len)
                $display("%0t: unit_length mismatch, expected %0d actual %0d",
                         $time, want.len, got.len);
              if (got.offs !== want.offs)
                $display("%0t: out_offset mismatch, expected %0d actual %0d",
                         $time, want.offs, got.offs);
              if (got.fin !== want.fin)
                $display("%0t: last_result mismatch, expected %b actual %b",
                         $time, want.fin, got.fin);
            end
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= expected_results.size();
    checked    <= n_checked;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the annexb_to_length_prefixed testbench: clock, reset, byte stimulus,
// prefix size writes and output back-pressure. Checking is done by
// annexb_stream_checker; depends on anb2lp_pkg and the converter RTL.
module tb_top;
  import anb2lp_pkg::*;

  localparam int PHASE_BYTES = 20;
  localparam int DRAIN_CYCLES = 8;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [PSIZE_W-1:0] cfg_data;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic [55:0]        m_tdata;
  logic [KIND_W-1:0]  m_tuser;
  logic               m_tlast;

  int fail_count;
  int pending;
  int checked;

  // Stimulus bookkeeping
  logic [7:0] au[$];
  logic [PSIZE_W-1:0] prefix_plan[8] = '{3'd1, 3'd7, 3'd0, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6};
  int  bytes_sent = 0;
  int  units_sent = 0;
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  quiet = 1'b0;

  annexb_to_length_prefixed dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  annexb_stream_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: stalls in random bursts, none once the run goes quiet
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // One byte transaction, with an optional idle burst in front
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_unit();
    foreach (au[i]) send_byte(au[i], i == au.size() - 1);
    units_sent++;
  endtask

  // Everything predicted has come out, then let the pipeline settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_prefix(input logic [PSIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_start_code(input int zeros);
    repeat (zeros) au.push_back(8'h00);
    au.push_back(START_CODE_BYTE);
  endfunction

  // Random NAL content: plain bytes, lone zeros, zero runs and stray 0x01
  function automatic void add_payload(input int len);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0, 1: au.push_back(8'h00);
        2: begin
          repeat ($urandom_range(2, 5)) au.push_back(8'h00);
          au.push_back(8'($urandom_range(2, 255)));
        end
        3: au.push_back(START_CODE_BYTE);
        default: au.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void build_good_unit();
    int nals;
    au.delete();
    add_start_code(($urandom_range(0, 4) == 0) ? $urandom_range(2, 6) : $urandom_range(2, 3));
    nals = $urandom_range(1, 4);
    for (int k = 0; k < nals; k++) begin
      add_payload(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12));
      if (k < nals - 1) add_start_code($urandom_range(2, 5));
    end
    case ($urandom_range(0, 5))
      0: repeat ($urandom_range(1, 4)) au.push_back(8'h00);
      1: add_start_code($urandom_range(2, 4));
      default: ;
    endcase
  endfunction

  function automatic void build_broken_unit();
    au.delete();
    case ($urandom_range(0, 4))
      0: begin
        // nonzero first byte
        au.push_back(8'($urandom_range(1, 255)));
        repeat ($urandom_range(0, 5)) au.push_back(8'($urandom_range(0, 255)));
      end
      1: repeat ($urandom_range(1, 6)) au.push_back(8'h00);
      2: begin
        au.push_back(8'h00);
        repeat ($urandom_range(1, 5)) au.push_back(8'($urandom_range(2, 255)));
      end
      3: begin
        // a single zero before 0x01 is not a start code
        au.push_back(8'h00);
        au.push_back(START_CODE_BYTE);
        au.push_back(8'($urandom_range(2, 255)));
      end
      default: begin
        au.push_back(8'h00);
        au.push_back(8'h00);
        au.push_back(8'($urandom_range(2, 255)));
      end
    endcase
  endfunction

  function automatic void build_random_unit();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      build_broken_unit();
    end else begin
      build_good_unit();
      if (pick == 2) begin
        // junk ahead of the first start code
        repeat ($urandom_range(1, 4)) au.push_front(8'($urandom_range(2, 255)));
        au.push_front(8'h00);
      end
    end
  endfunction

  initial begin : stimulus
    int phase_start;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed units at the reset prefix size
    au = '{8'h00, 8'h00, 8'h01, 8'hFF, 8'h00};
    send_unit();
    au = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
           8'h01, 8'h7F};
    send_unit();
    au = '{8'h05};
    send_unit();
    au = '{8'h00};
    send_unit();
    au = '{8'h00, 8'hAA, 8'h00, 8'h00, 8'h01};
    send_unit();

    // Random units, one prefix size per phase; the last phase never idles
    foreach (prefix_plan[p]) begin
      wait_drained();
      write_prefix(prefix_plan[p]);
      quiet     = (p == $size(prefix_plan) - 1);
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_random_unit();
        send_unit();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d access units over %0d prefix sizes plus the reset one.",
             bytes_sent, units_sent, $size(prefix_plan));
    $display("Checked %0d results: payload bytes, length records and error records.",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* annexb_to_length_prefixed.f */
sv/anb2lp_pkg.sv
sv/anb2lp_front.sv
sv/anb2lp_queue.sv
sv/anb2lp_back.sv
sv/annexb_to_length_prefixed.sv
tb/annexb_stream_checker.sv
tb/tb_top.sv
